// File: sv/sept_pkg.sv
// Shared constants for the stacker encoder pulse tracker.
`timescale 1ns / 1ps
package sept_pkg;
	localparam int CNT_W = 16;
	localparam int REG_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_VARIANT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_CHECK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_DA_PULSE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_PULSE = 2'd3;

	localparam logic [1:0] DIR_FWD = 2'd1;
	localparam logic [1:0] DIR_REV = 2'd2;

	localparam logic [CNT_W-1:0] CHK_A = CNT_W'(150);
	localparam logic [CNT_W-1:0] CHK_B = CNT_W'(240);
	localparam logic [CNT_W-1:0] CHK_C = CNT_W'(520);
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
endpackage

// File: sv/stacker_encoder_pulse_tracker.sv
// Top level of the stacker encoder pulse tracker: input stage, update logic, result register.
//  channel | signals                                        | direction
//  in      | in_valid/in_ready, kind home direction limit_value | into block
//  out     | out_valid/out_ready, counters and flags        | out of block
//  cfg     | cfg_valid/cfg_ready, cfg_index cfg_data        | into block
// One item per cycle while the result is not stalled; each item passes the
// input register, then the result register. The counter update is one
// combinational pass between the two. Reset clears counters, limits, config
// registers and valid flags. A stalled result holds and the input stage fills behind it.
`timescale 1ns / 1ps
module stacker_encoder_pulse_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic                          home,
	input  logic [1:0]                    direction,
	input  logic [15:0]                   limit_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [15:0]                   pulse_total,
	output logic [15:0]                   push_position,
	output logic [15:0]                   up_total,
	output logic [15:0]                   down_total,
	output logic                          limit_hit,
	output logic                          save_request,
	output logic                          peak_window,
	output logic                          peak_timer_restart,
	output logic                          dac_switch,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sept_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sept_pkg::REG_W-1:0]    cfg_data
);
	localparam int W = sept_pkg::CNT_W;

	// config registers
	logic         variant_q;
	logic         full_check_q;
	logic [W-1:0] full_da_pulse_q;
	logic [W-1:0] top_pulse_q;

	// state
	logic [W-1:0] pulse_q, active_q, pending_q, pos_q, up_q, down_q;
	logic         peak_q;

	// input stage
	logic         valid_s1, kind_s1, home_s1;
	logic [1:0]   dir_s1;
	logic [W-1:0] limit_s1;

	// result register
	logic         out_valid_q;
	logic [W-1:0] pulse_out_q, pos_out_q, up_out_q, down_out_q;
	logic         hit_out_q, save_out_q, peak_out_q, restart_out_q, dac_out_q;

	logic         advance;
	logic         fwd, rev, load, active_nz;
	logic [W-1:0] pulse_n, active_n, pending_n, pos_n, up_n, down_n, act_base;
	logic         peak_n, hit_n, save_n, restart_n, dac_n;
	logic [W-1:0] pos_inc;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q       <= 1'b0;
			full_check_q    <= 1'b0;
			full_da_pulse_q <= '0;
			top_pulse_q     <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sept_pkg::REG_VARIANT:       variant_q       <= cfg_data[0];
				sept_pkg::REG_FULL_CHECK:    full_check_q    <= cfg_data[0];
				sept_pkg::REG_FULL_DA_PULSE: full_da_pulse_q <= W'(cfg_data);
				sept_pkg::REG_TOP_PULSE:     top_pulse_q     <= W'(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1  <= kind;
			home_s1  <= home;
			dir_s1   <= direction;
			limit_s1 <= W'(limit_value);
		end
	end

	assign fwd     = (dir_s1 == sept_pkg::DIR_FWD);
	assign rev     = (dir_s1 == sept_pkg::DIR_REV);
	assign pos_inc = (pos_q == sept_pkg::CNT_MAX) ? pos_q : pos_q + W'(1);

	always_comb begin
		pulse_n   = pulse_q;
		active_n  = active_q;
		pending_n = pending_q;
		pos_n     = pos_q;
		up_n      = up_q;
		down_n    = down_q;
		peak_n    = peak_q;
		hit_n     = 1'b0;
		save_n    = 1'b0;
		restart_n = 1'b0;
		dac_n     = 1'b0;
		load      = (pending_q != '0);
		act_base  = load ? pending_q : active_q;
		active_nz = (act_base != '0);
		if (kind_s1) begin
			if (limit_s1 != '0) pending_n = limit_s1;
		end else begin
			if (!variant_q && home_s1) begin
				pos_n = '0;
			end else if (fwd) begin
				pos_n  = pos_inc;
				save_n = (pos_inc == sept_pkg::CHK_A) || (pos_inc == sept_pkg::CHK_B) ||
					(pos_inc == sept_pkg::CHK_C);
			end else if (variant_q && rev && pos_q != '0) begin
				pos_n = pos_q - W'(1);
			end
			pending_n = '0;
			active_n  = act_base;
			pulse_n   = (load ? '0 : pulse_q) + W'(1);
			if (active_nz) begin
				if (full_check_q) begin
					if (pulse_n == full_da_pulse_q) begin
						restart_n = 1'b1;
						peak_n    = 1'b1;
					end else if (pulse_n >= top_pulse_q) begin
						peak_n = 1'b0;
					end
				end
				if (variant_q || !home_s1) begin
					if (fwd) up_n = up_q + W'(1);
					else     down_n = down_q + W'(1);
				end
				if (pulse_n >= act_base) begin
					active_n = '0;
					hit_n    = 1'b1;
				end
				dac_n = (pulse_n == full_da_pulse_q) && fwd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q   <= '0;
			active_q  <= '0;
			pending_q <= '0;
			pos_q     <= '0;
			up_q      <= '0;
			down_q    <= '0;
			peak_q    <= 1'b0;
		end else if (advance) begin
			pulse_q   <= pulse_n;
			active_q  <= active_n;
			pending_q <= pending_n;
			pos_q     <= pos_n;
			up_q      <= up_n;
			down_q    <= down_n;
			peak_q    <= peak_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pulse_out_q   <= pulse_n;
			pos_out_q     <= pos_n;
			up_out_q      <= up_n;
			down_out_q    <= down_n;
			hit_out_q     <= hit_n;
			save_out_q    <= save_n;
			peak_out_q    <= peak_n;
			restart_out_q <= restart_n;
			dac_out_q     <= dac_n;
		end
	end

	assign out_valid          = out_valid_q;
	assign pulse_total        = pulse_out_q;
	assign push_position      = pos_out_q;
	assign up_total           = up_out_q;
	assign down_total         = down_out_q;
	assign limit_hit          = hit_out_q;
	assign save_request       = save_out_q;
	assign peak_window        = peak_out_q;
	assign peak_timer_restart = restart_out_q;
	assign dac_switch         = dac_out_q;
endmodule

// File: sv/sept_checker.sv
// Port-level checker for the stacker encoder pulse tracker, with its bind.
`timescale 1ns / 1ps
module sept_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] pulse_total,
	input logic [15:0] push_position,
	input logic        limit_hit,
	input logic        save_request,
	input logic        peak_window,
	input logic        peak_timer_restart
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_hit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && limit_hit |-> pulse_total != 16'd0)
		else $error("limit hit with zero pulse count");

	a_save_checkpoint: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && save_request |->
			push_position == 16'd150 || push_position == 16'd240 ||
			push_position == 16'd520)
		else $error("save request off checkpoint");

	a_restart_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && peak_timer_restart |-> peak_window)
		else $error("peak timer restart without open window");
endmodule

bind stacker_encoder_pulse_tracker sept_checker u_sept_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.out_valid          (out_valid),
	.out_ready          (out_ready),
	.pulse_total        (pulse_total),
	.push_position      (push_position),
	.limit_hit          (limit_hit),
	.save_request       (save_request),
	.peak_window        (peak_window),
	.peak_timer_restart (peak_timer_restart)
);

// File: sim/testbench.sv
// Self-checking testbench for the stacker encoder pulse tracker.
`timescale 1ns / 1ps
module testbench;
	localparam logic KIND_PULSE = 1'b0;
	localparam logic KIND_ARM = 1'b1;
	localparam logic [1:0] DIR_IDLE = 2'd0;
	localparam logic [1:0] DIR_OTHER = 2'd3;
	localparam int QUIET_LIMIT = 5000;
	localparam int MAX_REPORTS = 10;
	localparam int PHASE_ITEMS = 150;

	typedef struct packed {
		logic [sept_pkg::CNT_W-1:0] pulses;
		logic [sept_pkg::CNT_W-1:0] position;
		logic [sept_pkg::CNT_W-1:0] ups;
		logic [sept_pkg::CNT_W-1:0] downs;
		logic                       hit;
		logic                       save;
		logic                       window;
		logic                       restart;
		logic                       dac;
	} tracker_result_t;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	logic                           kind;
	logic                           home;
	logic [1:0]                     direction;
	logic [15:0]                    limit_value;
	logic                           out_valid;
	logic                           out_ready;
	logic [15:0]                    pulse_total;
	logic [15:0]                    push_position;
	logic [15:0]                    up_total;
	logic [15:0]                    down_total;
	logic                           limit_hit;
	logic                           save_request;
	logic                           peak_window;
	logic                           peak_timer_restart;
	logic                           dac_switch;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [sept_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [sept_pkg::REG_W-1:0]     cfg_data;

	// shadow of the block's registers and state
	logic                       shadow_variant = 1'b0;
	logic                       shadow_full_check = 1'b0;
	logic [sept_pkg::CNT_W-1:0] shadow_full_da = '0;
	logic [sept_pkg::CNT_W-1:0] shadow_top = '0;
	logic [sept_pkg::CNT_W-1:0] model_pulses = '0;
	logic [sept_pkg::CNT_W-1:0] model_limit = '0;
	logic [sept_pkg::CNT_W-1:0] model_pending = '0;
	logic [sept_pkg::CNT_W-1:0] model_position = '0;
	logic [sept_pkg::CNT_W-1:0] model_ups = '0;
	logic [sept_pkg::CNT_W-1:0] model_downs = '0;
	logic                       model_peak = 1'b0;

	tracker_result_t expected_q[$];
	tracker_result_t head;

	bit idle_on = 1'b1;
	int stall_left = 0;
	int quiet_cycles = 0;
	int mismatches = 0;
	int items_sent = 0;
	int results_seen = 0;
	int arms_sent = 0;
	int hits_seen = 0;
	int saves_seen = 0;
	int restarts_seen = 0;
	int dacs_seen = 0;
	int phases_run = 0;

	stacker_encoder_pulse_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.home(home),
		.direction(direction),
		.limit_value(limit_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pulse_total(pulse_total),
		.push_position(push_position),
		.up_total(up_total),
		.down_total(down_total),
		.limit_hit(limit_hit),
		.save_request(save_request),
		.peak_window(peak_window),
		.peak_timer_restart(peak_timer_restart),
		.dac_switch(dac_switch),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic push_forward();
		if (model_position != sept_pkg::CNT_MAX)
			model_position = model_position + sept_pkg::CNT_W'(1);
		return (model_position == sept_pkg::CHK_A) || (model_position == sept_pkg::CHK_B) ||
			(model_position == sept_pkg::CHK_C);
	endfunction

	function automatic tracker_result_t advance_tracker(input logic k, input logic h,
			input logic [1:0] d, input logic [sept_pkg::CNT_W-1:0] lim);
		tracker_result_t r;
		r = '0;
		if (k == KIND_ARM) begin
			if (lim != '0)
				model_pending = lim;
		end else begin
			if (!shadow_variant) begin
				if (h)
					model_position = '0;
				else if (d == sept_pkg::DIR_FWD)
					r.save = push_forward();
			end else begin
				if (d == sept_pkg::DIR_FWD)
					r.save = push_forward();
				else if (d == sept_pkg::DIR_REV && model_position != '0)
					model_position = model_position - sept_pkg::CNT_W'(1);
			end
			if (model_pending != '0) begin
				model_pulses = '0;
				model_limit = model_pending;
				model_pending = '0;
			end
			model_pulses = model_pulses + sept_pkg::CNT_W'(1);
			if (model_limit != '0) begin
				if (shadow_full_check) begin
					if (model_pulses == shadow_full_da) begin
						r.restart = 1'b1;
						model_peak = 1'b1;
					end else if (model_pulses >= shadow_top) begin
						model_peak = 1'b0;
					end
				end
				if (shadow_variant || !h) begin
					if (d == sept_pkg::DIR_FWD)
						model_ups = model_ups + sept_pkg::CNT_W'(1);
					else
						model_downs = model_downs + sept_pkg::CNT_W'(1);
				end
				if (model_pulses >= model_limit) begin
					model_limit = '0;
					r.hit = 1'b1;
				end
				if (model_pulses == shadow_full_da && d == sept_pkg::DIR_FWD)
					r.dac = 1'b1;
			end
		end
		r.pulses = model_pulses;
		r.position = model_position;
		r.ups = model_ups;
		r.downs = model_downs;
		r.window = model_peak;
		return r;
	endfunction

	task automatic send_item(input logic k, input logic h, input logic [1:0] d,
			input logic [15:0] lim);
		int gap;
		gap = idle_on ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		kind <= k;
		home <= h;
		direction <= d;
		limit_value <= lim;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		expected_q.push_back(advance_tracker(k, h, d, lim));
		items_sent++;
		if (k == KIND_ARM)
			arms_sent++;
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic [sept_pkg::CFG_IDX_W-1:0] idx,
			input logic [sept_pkg::REG_W-1:0] value);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			sept_pkg::REG_VARIANT: shadow_variant = value[0];
			sept_pkg::REG_FULL_CHECK: shadow_full_check = value[0];
			sept_pkg::REG_FULL_DA_PULSE: shadow_full_da = value;
			sept_pkg::REG_TOP_PULSE: shadow_top = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(input logic v, input logic fc, input logic [15:0] da,
			input logic [15:0] top);
		wait_for_results();
		write_register(sept_pkg::REG_VARIANT, sept_pkg::REG_W'(v));
		write_register(sept_pkg::REG_FULL_CHECK, sept_pkg::REG_W'(fc));
		write_register(sept_pkg::REG_FULL_DA_PULSE, da);
		write_register(sept_pkg::REG_TOP_PULSE, top);
	endtask

	task automatic random_traffic(input int n);
		logic k;
		logic h;
		logic [1:0] d;
		logic [15:0] lim;
		int s;
		for (int i = 0; i < n; i++) begin
			k = ($urandom_range(0, 99) < 10) ? KIND_ARM : KIND_PULSE;
			s = $urandom_range(0, 9);
			if (s < 7)
				lim = 16'($urandom_range(1, 40));
			else if (s == 7)
				lim = '0;
			else
				lim = 16'($urandom_range(0, 65535));
			h = shadow_variant ? ($urandom_range(0, 4) == 0) : ($urandom_range(0, 99) < 2);
			s = $urandom_range(0, 9);
			if (s < 6)
				d = sept_pkg::DIR_FWD;
			else if (s < 8)
				d = sept_pkg::DIR_REV;
			else if (s == 8)
				d = DIR_IDLE;
			else
				d = DIR_OTHER;
			send_item(k, h, d, lim);
		end
	endtask

	task automatic test_directed();
		// reset values: no limit, so up and down totals stay at zero
		send_item(KIND_PULSE, 1'b0, sept_pkg::DIR_FWD, 16'h0000);
		send_item(KIND_ARM, 1'b0, DIR_IDLE, 16'h0000);
		send_item(KIND_PULSE, 1'b0, DIR_OTHER, 16'hFFFF);
		write_all(1'b0, 1'b1, 16'd3, 16'd5);
		// zero arm keeps the pending limit
		send_item(KIND_ARM, 1'b0, sept_pkg::DIR_FWD, 16'd7);
		send_item(KIND_ARM, 1'b1, sept_pkg::DIR_REV, 16'd0);
		send_item(KIND_PULSE, 1'b0, sept_pkg::DIR_FWD, 16'd0);
		send_item(KIND_PULSE, 1'b0, sept_pkg::DIR_REV, 16'd0);
		send_item(KIND_PULSE, 1'b0, sept_pkg::DIR_FWD, 16'd0);
		send_item(KIND_PULSE, 1'b0, DIR_IDLE, 16'd0);
		send_item(KIND_PULSE, 1'b0, DIR_OTHER, 16'd0);
		send_item(KIND_PULSE, 1'b1, sept_pkg::DIR_FWD, 16'd0);
		send_item(KIND_PULSE, 1'b0, sept_pkg::DIR_FWD, 16'd0);
		send_item(KIND_PULSE, 1'b0, sept_pkg::DIR_FWD, 16'd0);
		send_item(KIND_ARM, 1'b0, sept_pkg::DIR_FWD, 16'hFFFF);
		send_item(KIND_PULSE, 1'b0, sept_pkg::DIR_REV, 16'd0);
		write_all(1'b1, 1'b1, 16'hFFFF, 16'h0000);
		send_item(KIND_ARM, 1'b1, DIR_OTHER, 16'd1);
		send_item(KIND_PULSE, 1'b1, sept_pkg::DIR_REV, 16'd0);
		send_item(KIND_PULSE, 1'b0, sept_pkg::DIR_REV, 16'd0);
		send_item(KIND_PULSE, 1'b0, sept_pkg::DIR_REV, 16'd0);
		send_item(KIND_ARM, 1'b0, sept_pkg::DIR_REV, 16'd2);
		send_item(KIND_PULSE, 1'b0, sept_pkg::DIR_REV, 16'd0);
		send_item(KIND_PULSE, 1'b1, sept_pkg::DIR_FWD, 16'd0);
	endtask

	task automatic test_backpressure();
		idle_on = 1'b0;
		random_traffic(2);
		stall_left = 200;
		random_traffic(30);
		wait_for_results();
		idle_on = 1'b1;
	endtask

	task automatic run_phase(input logic v, input logic fc, input logic [15:0] da,
			input logic [15:0] top, input bit idling);
		write_all(v, fc, da, top);
		idle_on = idling;
		random_traffic(PHASE_ITEMS);
		idle_on = 1'b1;
		phases_run++;
	endtask

	task automatic test_random_phases();
		run_phase(1'b0, 1'b1, 16'd3, 16'd8, 1'b1);
		run_phase(1'b1, 1'b1, 16'd12, 16'd20, 1'b1);
		run_phase(1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0);
		run_phase(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1);
		run_phase(1'b0, 1'b1, 16'd6, 16'd2, 1'b1);
		run_phase(1'($urandom_range(0, 1)), 1'b1, 16'($urandom_range(1, 40)),
			16'($urandom_range(1, 40)), 1'b1);
	endtask

	task automatic test_checkpoints();
		idle_on = 1'b0;
		// home clears position, then forward pulses pass every checkpoint
		write_all(1'b0, 1'b1, 16'd200, 16'd300);
		send_item(KIND_ARM, 1'b0, sept_pkg::DIR_FWD, 16'hFFFF);
		send_item(KIND_PULSE, 1'b1, sept_pkg::DIR_FWD, 16'd0);
		for (int i = 0; i < 521; i++)
			send_item(KIND_PULSE, 1'b0, sept_pkg::DIR_FWD, 16'd0);
		// reverse walks position back down under a short limit
		write_all(1'b1, 1'b0, 16'd0, 16'd0);
		send_item(KIND_ARM, 1'b0, sept_pkg::DIR_REV, 16'd5);
		for (int i = 0; i < 5; i++)
			send_item(KIND_PULSE, 1'b0, sept_pkg::DIR_REV, 16'd0);
		wait_for_results();
		idle_on = 1'b1;
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("result %0d: %s expected %0d got %0d", results_seen, name, want, got);
		end
	endtask

	initial begin
		int g;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (!idle_on) begin
				out_ready <= 1'b1;
			end else begin
				g = pick_gap();
				if (g == 0) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					stall_left = g - 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result %0d arrived with no item outstanding", results_seen);
			end else begin
				head = expected_q.pop_front();
				check_field("pulse_total", 32'(head.pulses), 32'(pulse_total));
				check_field("push_position", 32'(head.position), 32'(push_position));
				check_field("up_total", 32'(head.ups), 32'(up_total));
				check_field("down_total", 32'(head.downs), 32'(down_total));
				check_field("limit_hit", 32'(head.hit), 32'(limit_hit));
				check_field("save_request", 32'(head.save), 32'(save_request));
				check_field("peak_window", 32'(head.window), 32'(peak_window));
				check_field("peak_timer_restart", 32'(head.restart),
					32'(peak_timer_restart));
				check_field("dac_switch", 32'(head.dac), 32'(dac_switch));
				hits_seen += int'(head.hit);
				saves_seen += int'(head.save);
				restarts_seen += int'(head.restart);
				dacs_seen += int'(head.dac);
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[stacker_encoder_pulse_tracker] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = 1'b0;
		home = 1'b0;
		direction = DIR_IDLE;
		limit_value = '0;
		cfg_valid = 1'b0;
		cfg_index = sept_pkg::REG_VARIANT;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_backpressure();
		test_random_phases();
		test_checkpoints();
		wait_for_results();
		$display("ran %0d items (%0d arms) over %0d random register settings, %0d results checked",
			items_sent, arms_sent, phases_run, results_seen);
		$display("saw %0d limit hits, %0d checkpoint saves, %0d window restarts, %0d DAC requests",
			hits_seen, saves_seen, restarts_seen, dacs_seen);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("[stacker_encoder_pulse_tracker] OK");
		else
			$display("[stacker_encoder_pulse_tracker] ERROR");
		$finish;
	end
endmodule
